// ----- sv/non_restoring_divider_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the non-restoring divider
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef NON_RESTORING_DIVIDER_TOP_ASSERT_SVH
`define NON_RESTORING_DIVIDER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/nrdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// Non-restoring divider package
// Shared constants for the divider cells, correction stage and top level.
// ----------------------------------------------------------------------------
package nrdiv_pkg;

    // Default operand width in bits.
    localparam int DEFAULT_WIDTH = 16;

endpackage

// ----- sv/nrdiv_cell.sv -----
// ----------------------------------------------------------------------------
// Non-restoring divider cell
// One quotient bit per cell: shift, add or subtract the divisor, register.
// ----------------------------------------------------------------------------
`include "non_restoring_divider_top_assert.svh"

module nrdiv_cell #(
    parameter int WIDTH = nrdiv_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH:0]   in_a,
    input  logic [WIDTH-1:0] in_q,
    input  logic [WIDTH-1:0] in_m,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH:0]   out_a,
    output logic [WIDTH-1:0] out_q,
    output logic [WIDTH-1:0] out_m
);

    logic             valid_reg;
    logic [WIDTH:0]   a_reg;
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   a_next;
    logic [WIDTH-1:0] q_next;

    // The partial remainder and quotient shift together as one combined value.
    assign shifted = {in_a[WIDTH-1:0], in_q[WIDTH-1]};
    assign m_ext   = {1'b0, in_m};
    assign a_next  = in_a[WIDTH] ? (shifted + m_ext) : (shifted - m_ext);
    assign q_next  = {in_q[WIDTH-2:0], ~a_next[WIDTH]};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_reg <= a_next;
            q_reg <= q_next;
            m_reg <= in_m;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_q     = q_reg;
    assign out_m     = m_reg;

    `NRD_ASSERT_NEXT(a_cell_hold, valid_reg && !out_ready, valid_reg && $stable(a_reg), "cell dropped a stalled beat")
    `NRD_ASSERT_SAME(a_cell_ready, !valid_reg, in_ready, "empty cell refused a beat")
    `NRD_ASSERT_SAME(a_cell_qbit, valid_reg, q_reg[0] == !a_reg[WIDTH], "quotient bit disagrees with remainder sign")

endmodule

// ----- sv/nrdiv_fix.sv -----
// ----------------------------------------------------------------------------
// Non-restoring divider correction stage
// Adds the divisor back to a negative remainder and holds the result beat.
// ----------------------------------------------------------------------------
`include "non_restoring_divider_top_assert.svh"

module nrdiv_fix #(
    parameter int WIDTH = nrdiv_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH:0]   in_a,
    input  logic [WIDTH-1:0] in_q,
    input  logic [WIDTH-1:0] in_m,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             divide_by_zero
);

    logic             valid_reg;
    logic [WIDTH-1:0] quot_reg;
    logic [WIDTH-1:0] rem_reg;
    logic             dz_reg;
    logic [WIDTH-1:0] rem_next;

    // A zero divisor leaves the dividend in the remainder and all ones in
    // the quotient on its own, so only the flag needs deriving here.
    assign rem_next = in_a[WIDTH] ? (in_a[WIDTH-1:0] + in_m) : in_a[WIDTH-1:0];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            quot_reg <= in_q;
            rem_reg  <= rem_next;
            dz_reg   <= (in_m == '0);
        end
    end

    assign out_valid      = valid_reg;
    assign quotient       = quot_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = dz_reg;

    `NRD_ASSERT_SAME(a_fix_dz, valid_reg && dz_reg, quot_reg == {WIDTH{1'b1}}, "zero divisor without all-ones quotient")
    `NRD_ASSERT_NEXT(a_fix_hold, valid_reg && !out_ready, valid_reg && $stable(rem_reg), "result beat changed while stalled")

endmodule

// ----- sv/non_restoring_divider_top.sv -----
// ----------------------------------------------------------------------------
// Non-restoring unsigned divider, top level
// Stream in dividend and divisor, stream out quotient, remainder and flag.
// ----------------------------------------------------------------------------
// The divider is a chain of WIDTH cells, each producing one quotient bit,
// followed by a correction register that fixes a negative remainder. It
// accepts one beat per clock while the output is not stalled, and returns
// one result beat per input beat, in order, after it passes through the
// cell chain and then the correction register. Every cell forwards its
// beat whenever the cell after it is empty or moving, so bubbles are
// absorbed while the output waits. A zero divisor gives an all-ones
// quotient, the dividend as remainder, and sets the flag in tuser.
// ----------------------------------------------------------------------------
module non_restoring_divider_top #(
    parameter  int WIDTH   = nrdiv_pkg::DEFAULT_WIDTH,
    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // dividend, divisor, zero fill
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // quotient, remainder, zero fill
    output logic               m_axis_tuser   // divide_by_zero
);

    logic [WIDTH:0]   a_s     [0:WIDTH];
    logic [WIDTH-1:0] q_s     [0:WIDTH];
    logic [WIDTH-1:0] m_s     [0:WIDTH];
    logic             valid_s [0:WIDTH];
    logic             ready_s [0:WIDTH];
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;

    assign a_s[0]        = '0;
    assign q_s[0]        = s_axis_tdata[WIDTH-1:0];
    assign m_s[0]        = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign valid_s[0]    = s_axis_tvalid;
    assign s_axis_tready = ready_s[0];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        nrdiv_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_s[i]),
            .in_ready (ready_s[i]),
            .in_a     (a_s[i]),
            .in_q     (q_s[i]),
            .in_m     (m_s[i]),
            .out_valid(valid_s[i+1]),
            .out_ready(ready_s[i+1]),
            .out_a    (a_s[i+1]),
            .out_q    (q_s[i+1]),
            .out_m    (m_s[i+1])
        );
    end

    nrdiv_fix #(
        .WIDTH(WIDTH)
    ) u_fix (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_s[WIDTH]),
        .in_ready      (ready_s[WIDTH]),
        .in_a          (a_s[WIDTH]),
        .in_q          (q_s[WIDTH]),
        .in_m          (m_s[WIDTH]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .quotient      (quotient),
        .remainder     (remainder),
        .divide_by_zero(m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_W'({remainder, quotient});

endmodule
